FILE: rtl/pwm_duty_frequency_meter_assert.svh
// ----------------------------------------------------------------------------
// pwm duty/frequency meter assertion macros
// clocked property checks that compile away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef PWM_DUTY_FREQUENCY_METER_ASSERT_SVH
`define PWM_DUTY_FREQUENCY_METER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PDFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdfm assertion failed");
// next-cycle implication
`define PDFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdfm assertion failed");
`else
`define PDFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PDFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pdfm_pkg.sv
// ----------------------------------------------------------------------------
// pdfm_pkg
// shared widths, constants and types of the pwm duty/frequency meter
// ----------------------------------------------------------------------------
`default_nettype none

package pdfm_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int RATE_W          = 20;
	localparam int TICK_OUT_W      = 24;
	localparam int DUTY_W          = 7;
	localparam int FREQ_W          = 20;
	localparam int QUOT_W          = FREQ_W;
	localparam int STEP_W          = $clog2(QUOT_W);

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(7812);
	localparam logic [DUTY_W-1:0] DUTY_MAX   = DUTY_W'(100);

	// which quotient the shared divider produces
	typedef enum logic {
		DIV_DUTY = 1'b0,
		DIV_FREQ = 1'b1
	} div_mode_t;

	typedef struct packed {
		logic      start;
		div_mode_t mode;
	} div_req_t;

	// status from the edge tracker
	typedef struct packed {
		logic done;      // this beat closed a high or low measurement
		logic low_seen;  // a low time has been measured
	} trk_stat_t;

endpackage

`default_nettype wire

FILE: rtl/pdfm_in_if.sv
// ----------------------------------------------------------------------------
// pdfm_in_if
// sample channel: one pwm level per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pdfm_in_if;
	logic valid;
	logic ready;
	logic pwm_level;

	modport source (output valid, output pwm_level, input ready);
	modport sink   (input valid, input pwm_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/pdfm_out_if.sv
// ----------------------------------------------------------------------------
// pdfm_out_if
// result channel: times, duty and frequency per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface pdfm_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [pdfm_pkg::TICK_OUT_W-1:0]       high_ticks;
	logic [pdfm_pkg::TICK_OUT_W-1:0]       low_ticks;
	logic [pdfm_pkg::DUTY_W-1:0]           duty_percent;
	logic [pdfm_pkg::FREQ_W-1:0]           freq_hz;
	logic                                  both_valid;

	modport source (output valid, output high_ticks, output low_ticks,
		output duty_percent, output freq_hz, output both_valid, input ready);
	modport sink (input valid, input high_ticks, input low_ticks,
		input duty_percent, input freq_hz, input both_valid, output ready);
endinterface

`default_nettype wire

FILE: rtl/pdfm_tracker.sv
// ----------------------------------------------------------------------------
// pdfm_tracker
// edge detection, phase tracking and saturating high/low tick counting
// ----------------------------------------------------------------------------
`default_nettype none

module pdfm_tracker #(
	parameter int COUNT_WIDTH = pdfm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire logic                   level,
	output pdfm_pkg::trk_stat_t         stat,
	output logic [COUNT_WIDTH-1:0]      hi_time,
	output logic [COUNT_WIDTH-1:0]      lo_time
);

	typedef enum logic [2:0] {
		PH_WAIT = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	phase_t                  phase_q;
	logic                    last_q;
	logic                    low_seen_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [COUNT_WIDTH-1:0]  high_q;
	logic [COUNT_WIDTH-1:0]  low_q;
	logic                    rising;
	logic                    falling;
	logic [COUNT_WIDTH-1:0]  count_inc;

	assign rising    = level & ~last_q;
	assign falling   = ~level & last_q;
	assign count_inc = (count_q != CNT_MAX) ? count_q + CNT_ONE : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			last_q     <= 1'b0;
			low_seen_q <= 1'b0;
			count_q    <= '0;
			high_q     <= '0;
			low_q      <= '0;
		end else if (accept) begin
			last_q <= level;
			case (phase_q)
				PH_HIGH: begin
					if (falling) begin
						high_q  <= count_q;
						count_q <= CNT_ONE;
						phase_q <= PH_LOW;
					end else begin
						count_q <= count_inc;
					end
				end
				PH_LOW: begin
					if (rising) begin
						low_q      <= count_q;
						low_seen_q <= 1'b1;
						count_q    <= CNT_ONE;
						phase_q    <= PH_HIGH;
					end else begin
						count_q <= count_inc;
					end
				end
				default: begin
					// waiting for the first rising edge
					if (rising) begin
						count_q <= CNT_ONE;
						phase_q <= PH_HIGH;
					end
				end
			endcase
		end
	end

	assign stat.done     = accept & (((phase_q == PH_HIGH) & falling) |
		((phase_q == PH_LOW) & rising));
	assign stat.low_seen = low_seen_q;
	assign hi_time       = high_q;
	assign lo_time       = low_q;

endmodule

`default_nettype wire

FILE: rtl/pdfm_divider.sv
// ----------------------------------------------------------------------------
// pdfm_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pdfm_divider #(
	parameter int  DEN_W = pdfm_pkg::COUNT_WIDTH_DEF + 1,
	localparam int QW    = pdfm_pkg::QUOT_W,
	localparam int DW    = DEN_W + QW - 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pdfm_pkg::div_req_t req,
	input  wire logic [DW-1:0]      num,
	input  wire logic [DEN_W-1:0]   den,
	output logic                    done,
	output logic [QW-1:0]           quot
);

	localparam int CW = pdfm_pkg::STEP_W;
	localparam int DS = pdfm_pkg::DUTY_W - 1;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] q_q;
	logic          ge;

	// duty quotient fits DUTY_W bits since high <= period
	assign ge   = rem_q >= den_q;
	assign done = busy_q && (cnt_q == '0);
	assign quot = {q_q[QW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= (req.mode == pdfm_pkg::DIV_DUTY) ? CW'(DS) : CW'(QW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num;
			q_q   <= '0;
			if (req.mode == pdfm_pkg::DIV_DUTY) begin
				den_q <= DW'({den, {DS{1'b0}}});
			end else begin
				den_q <= {den, {(QW - 1){1'b0}}};
			end
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			q_q   <= quot;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pwm_duty_frequency_meter.sv
// ----------------------------------------------------------------------------
// pwm_duty_frequency_meter
// pwm high/low time, duty percent and frequency from per-tick level samples
// ----------------------------------------------------------------------------
// Each sample beat carries the level of the measured line at one timer tick.
// After reset the meter waits for the first rising edge, then counts high
// ticks up to the falling edge and low ticks up to the next rising edge,
// saturating at 2^COUNT_WIDTH-1. Every falling edge, and every rising edge
// after the first, yields one result beat: both times (clipped to 24 bits),
// duty = floor(100*high/period) and freq = floor(tick_rate_hz/period), with
// both_valid set once a low time exists. A sample that closes a measurement
// occupies the meter: the sequencer loads one shared restoring divider, which
// produces 7 duty bits and then 20 frequency bits, one bit per cycle, and the
// result then waits until the output register is free; other samples do not
// hold the meter. The finished result sits in an output register, so new
// samples are taken while it waits. tick_rate_hz resets to 7812; the user must
// write it through cfg_we/cfg_data only while the meter is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pwm_duty_frequency_meter_assert.svh"

module pwm_duty_frequency_meter #(
	parameter int COUNT_WIDTH = pdfm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [pdfm_pkg::RATE_W-1:0]   cfg_data,
	pdfm_in_if.sink                            sample,
	pdfm_out_if.source                         result
);

	localparam int PW = COUNT_WIDTH + 1;            // period width
	localparam int QW = pdfm_pkg::QUOT_W;
	localparam int DW = PW + QW - 1;                // divider datapath width
	localparam int TW = pdfm_pkg::TICK_OUT_W;
	localparam int RW = pdfm_pkg::RATE_W;
	localparam int YW = pdfm_pkg::DUTY_W;
	localparam int FW = pdfm_pkg::FREQ_W;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,  // taking samples
		ST_LOAD = 5'b00010,  // start the duty division
		ST_DUTY = 5'b00100,  // duty bits in progress
		ST_FREQ = 5'b01000,  // frequency bits in progress
		ST_HOLD = 5'b10000   // waiting for the output register
	} state_t;

	state_t                   state_q;
	logic [RW-1:0]            rate_q;
	logic                     acc;
	pdfm_pkg::trk_stat_t      trk_stat;
	logic [COUNT_WIDTH-1:0]   hi_time;
	logic [COUNT_WIDTH-1:0]   lo_time;
	logic [PW-1:0]            period;
	logic                     zero_period;
	logic [DW-1:0]            hi_ext;
	logic [DW-1:0]            div_num;
	pdfm_pkg::div_req_t       div_req;
	logic                     div_done;
	logic [QW-1:0]            div_quot;
	logic [YW-1:0]            duty_q;
	logic [FW-1:0]            freq_q;
	logic                     out_free;
	logic                     out_load;
	logic                     out_valid_q;
	logic [TW-1:0]            high_sat;
	logic [TW-1:0]            low_sat;
	logic [TW-1:0]            high_out_q;
	logic [TW-1:0]            low_out_q;
	logic [YW-1:0]            duty_out_q;
	logic [FW-1:0]            freq_out_q;
	logic                     both_out_q;

	// tick rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= pdfm_pkg::RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_data;
		end
	end

	// samples are only taken between measurements
	assign sample.ready = (state_q == ST_IDLE);
	assign acc          = sample.valid & sample.ready;

	pdfm_tracker #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (acc),
		.level   (sample.pwm_level),
		.stat    (trk_stat),
		.hi_time (hi_time),
		.lo_time (lo_time)
	);

	// period never wraps: one extra bit
	assign period      = {1'b0, hi_time} + {1'b0, lo_time};
	assign zero_period = (period == '0);

	// 100*high as shift-add: 64 + 32 + 4
	assign hi_ext = DW'(hi_time);

	always_comb begin
		if (state_q == ST_LOAD) begin
			div_num = (hi_ext << 6) + (hi_ext << 5) + (hi_ext << 2);
		end else begin
			div_num = DW'(rate_q);
		end
	end

	// duty division starts from the load state, frequency right after duty ends
	assign div_req.start = (state_q == ST_LOAD) || ((state_q == ST_DUTY) && div_done);
	assign div_req.mode  = (state_q == ST_LOAD) ? pdfm_pkg::DIV_DUTY : pdfm_pkg::DIV_FREQ;

	pdfm_divider #(
		.DEN_W (PW)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (period),
		.done   (div_done),
		.quot   (div_quot)
	);

	// output register frees up as the current beat leaves
	assign out_free = !out_valid_q || result.ready;
	assign out_load = (state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (trk_stat.done) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_DUTY;
				end
				ST_DUTY: begin
					if (div_done) begin
						state_q <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (div_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// quotient capture
	always_ff @(posedge clk) begin
		if ((state_q == ST_DUTY) && div_done) begin
			duty_q <= div_quot[YW-1:0];
		end
		if ((state_q == ST_FREQ) && div_done) begin
			freq_q <= div_quot[FW-1:0];
		end
	end

	// clip tick counts to the 24-bit result fields
	always_comb begin
		if ((COUNT_WIDTH > TW) && ((hi_time >> TW) != '0)) begin
			high_sat = '1;
		end else begin
			high_sat = TW'(hi_time);
		end
		if ((COUNT_WIDTH > TW) && ((lo_time >> TW) != '0)) begin
			low_sat = '1;
		end else begin
			low_sat = TW'(lo_time);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			high_out_q <= high_sat;
			low_out_q  <= low_sat;
			duty_out_q <= zero_period ? '0 : duty_q;
			freq_out_q <= zero_period ? '0 : freq_q;
			both_out_q <= trk_stat.low_seen;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.high_ticks   = high_out_q;
	assign result.low_ticks    = low_out_q;
	assign result.duty_percent = duty_out_q;
	assign result.freq_hz      = freq_out_q;
	assign result.both_valid   = both_out_q;

	// a closed measurement always kicks off the duty division
	`PDFM_ASSERT_NEXT(a_done_starts_div, clk, arst_n, trk_stat.done, state_q == ST_LOAD)
	// the divider only finishes while the sequencer waits for it
	`PDFM_ASSERT_NOW(a_div_done_owned, clk, arst_n, div_done, state_q == ST_DUTY || state_q == ST_FREQ)
	// duty never exceeds one hundred percent
	`PDFM_ASSERT_NOW(a_duty_range, clk, arst_n, result.valid, result.duty_percent <= pdfm_pkg::DUTY_MAX)
	// once both times are known the low time is nonzero
	`PDFM_ASSERT_NOW(a_low_nonzero, clk, arst_n, result.valid && result.both_valid, result.low_ticks != '0)

endmodule

`default_nettype wire
